@@ src/tlc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and constants of the two-road traffic light controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

   // Lamp codes of one head: bit0 red, bit1 yellow, bit2 green.
   localparam logic [2:0] LAMP_OFF    = 3'b000;
   localparam logic [2:0] LAMP_RED    = 3'b001;
   localparam logic [2:0] LAMP_YELLOW = 3'b010;
   localparam logic [2:0] LAMP_GREEN  = 3'b100;

   // Values after reset.
   localparam int RED_RESET    = 5;
   localparam int YELLOW_RESET = 2;
   localparam int GREEN_RESET  = 3;
   localparam int WALK_RESET   = 20;

   // The buzzer may sound once the phase counter is at or below this value.
   localparam logic [7:0] BEEP_WINDOW = 8'd3;

   localparam int WALK_W = 10;

   // Edited colour codes as shown on the result channel.
   localparam logic [1:0] SHOW_RED    = 2'd0;
   localparam logic [1:0] SHOW_YELLOW = 2'd1;
   localparam logic [1:0] SHOW_GREEN  = 2'd2;

   typedef enum logic [4:0] {
      PH_INIT       = 5'b00001,
      PH_TWO_GREEN  = 5'b00010,
      PH_TWO_YELLOW = 5'b00100,
      PH_ONE_GREEN  = 5'b01000,
      PH_ONE_YELLOW = 5'b10000
   } phase_type;

   typedef enum logic [3:0] {
      EC_INIT   = 4'b0001,
      EC_RED    = 4'b0010,
      EC_YELLOW = 4'b0100,
      EC_GREEN  = 4'b1000
   } edit_colour_type;

   typedef enum logic [3:0] {
      WC_NONE   = 4'b0001,
      WC_GREEN  = 4'b0010,
      WC_YELLOW = 4'b0100,
      WC_RED    = 4'b1000
   } walk_colour_type;

   typedef struct packed {
      logic second_tick;
      logic blink_tick;
      logic beep_tick;
      logic mode_press;
      logic mode_long_press;
      logic time_press;
      logic enter_press;
      logic walk_request;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] road_one_lamps;
      logic [2:0] road_two_lamps;
      logic [2:0] walk_lamps;
      logic       buzzer_on;
      logic [7:0] left_display;
      logic [7:0] right_display;
      logic [6:0] edit_value;
      logic       in_manual;
      logic [1:0] edited_colour;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ src/tlc_if.sv @@
// ----------------------------------------------------------------------------
// tlc_if
// Valid/ready channels of the controller: request events in, lamp and
// display results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlc_req_if;
   logic valid;
   logic ready;
   logic second_tick;
   logic blink_tick;
   logic beep_tick;
   logic mode_press;
   logic mode_long_press;
   logic time_press;
   logic enter_press;
   logic walk_request;

   modport source (
      output valid, second_tick, blink_tick, beep_tick, mode_press,
             mode_long_press, time_press, enter_press, walk_request,
      input  ready
   );
   modport sink (
      input  valid, second_tick, blink_tick, beep_tick, mode_press,
             mode_long_press, time_press, enter_press, walk_request,
      output ready
   );
endinterface

interface tlc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] road_one_lamps;
   logic [2:0] road_two_lamps;
   logic [2:0] walk_lamps;
   logic       buzzer_on;
   logic [7:0] left_display;
   logic [7:0] right_display;
   logic [6:0] edit_value;
   logic       in_manual;
   logic [1:0] edited_colour;

   modport source (
      output valid, road_one_lamps, road_two_lamps, walk_lamps, buzzer_on,
             left_display, right_display, edit_value, in_manual, edited_colour,
      input  ready
   );
   modport sink (
      input  valid, road_one_lamps, road_two_lamps, walk_lamps, buzzer_on,
             left_display, right_display, edit_value, in_manual, edited_colour,
      output ready
   );
endinterface

`default_nettype wire

@@ src/tlc_engine.sv @@
// ----------------------------------------------------------------------------
// tlc_engine
// Controller state and its one-request update: phase sequencer, countdowns,
// manual editing with duration rebalancing, and the pedestrian walk head.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_engine #(
   parameter int MAX_DURATION = 99
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step_go,
   input  wire tlc_pkg::req_payload_type req_data,
   output tlc_pkg::rsp_payload_type     rsp_data
);
   import tlc_pkg::*;

   localparam int DUR_W = $clog2(MAX_DURATION + 1);
   localparam int SUM_W = DUR_W + 2;
   localparam logic [DUR_W-1:0] DUR_MAX = DUR_W'(MAX_DURATION);
   localparam logic [DUR_W-1:0] DUR_ONE = DUR_W'(1);

   logic                  manual_ff, manual_in;
   phase_type             phase_ff, phase_in;
   logic [7:0]            pcount_ff, pcount_in;
   logic [7:0]            count_one_ff, count_one_in;
   logic [7:0]            count_two_ff, count_two_in;
   logic [DUR_W-1:0]      red_ff, red_in;
   logic [DUR_W-1:0]      yellow_ff, yellow_in;
   logic [DUR_W-1:0]      green_ff, green_in;
   edit_colour_type       ecol_ff, ecol_in;
   logic [DUR_W-1:0]      ebuf_ff, ebuf_in;
   logic                  walk_active_ff, walk_active_in;
   logic [WALK_W-1:0]     walk_rem_ff, walk_rem_in;
   walk_colour_type       wcol_ff, wcol_in;
   logic                  beep_ff, beep_in;
   logic [8:0]            lamp_ff, lamp_in;
   logic                  buzzer_ff, buzzer_in;

   // Twice the cycle length, kept to the width of the walk timer.
   function automatic logic [WALK_W-1:0] walk_reload(
      input logic [DUR_W-1:0] r, input logic [DUR_W-1:0] y, input logic [DUR_W-1:0] g
   );
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(r) + SUM_W'(y) + SUM_W'(g);
      return WALK_W'({sum, 1'b0});
   endfunction

   // Difference of two durations, held to the legal duration range.
   function automatic logic [DUR_W-1:0] clamp_diff(
      input logic [DUR_W-1:0] a, input logic [DUR_W-1:0] b
   );
      logic signed [DUR_W:0] diff;
      diff = $signed({1'b0, a}) - $signed({1'b0, b});
      if (diff < $signed((DUR_W+1)'(1))) begin
         return DUR_ONE;
      end else if (diff > $signed({1'b0, DUR_MAX})) begin
         return DUR_MAX;
      end
      return DUR_W'(diff);
   endfunction

   always_comb begin
      edit_colour_type   c;
      edit_colour_type   c_next;
      logic [2:0]        blink_bit;
      logic [DUR_W-1:0]  stored;
      logic [DUR_W-1:0]  r, y, g;

      manual_in      = manual_ff;
      phase_in       = phase_ff;
      pcount_in      = pcount_ff;
      count_one_in   = count_one_ff;
      count_two_in   = count_two_ff;
      red_in         = red_ff;
      yellow_in      = yellow_ff;
      green_in       = green_ff;
      ecol_in        = ecol_ff;
      ebuf_in        = ebuf_ff;
      walk_active_in = walk_active_ff;
      walk_rem_in    = walk_rem_ff;
      wcol_in        = wcol_ff;
      beep_in        = beep_ff;
      lamp_in        = lamp_ff;
      buzzer_in      = buzzer_ff;
      c              = EC_RED;
      c_next         = EC_RED;
      blink_bit      = LAMP_RED;
      stored         = DUR_ONE;
      r              = red_ff;
      y              = yellow_ff;
      g              = green_ff;

      if (!manual_ff) begin
         if (req_data.second_tick) begin
            unique case (phase_ff)
               PH_INIT: begin
                  pcount_in    = 8'(green_ff);
                  count_one_in = 8'(red_ff);
                  count_two_in = 8'(green_ff);
                  phase_in     = PH_TWO_GREEN;
               end
               PH_TWO_GREEN: begin
                  pcount_in    = pcount_ff - 8'd1;
                  lamp_in[5:3] = LAMP_GREEN;
                  lamp_in[2:0] = LAMP_RED;
                  wcol_in      = WC_GREEN;
                  if (pcount_in == 8'd0) begin
                     pcount_in    = 8'(yellow_ff);
                     count_one_in = count_one_ff - 8'd1;
                     count_two_in = 8'(yellow_ff);
                     phase_in     = PH_TWO_YELLOW;
                     lamp_in[5:3] = LAMP_YELLOW;
                     wcol_in      = WC_YELLOW;
                  end else begin
                     count_one_in = count_one_ff - 8'd1;
                     count_two_in = count_two_ff - 8'd1;
                  end
               end
               PH_TWO_YELLOW: begin
                  pcount_in    = pcount_ff - 8'd1;
                  lamp_in[5:3] = LAMP_YELLOW;
                  lamp_in[2:0] = LAMP_RED;
                  wcol_in      = WC_YELLOW;
                  if (pcount_in == 8'd0) begin
                     pcount_in    = 8'(green_ff);
                     count_one_in = 8'(green_ff);
                     count_two_in = 8'(red_ff);
                     phase_in     = PH_ONE_GREEN;
                     lamp_in[2:0] = LAMP_GREEN;
                     lamp_in[5:3] = LAMP_RED;
                     wcol_in      = WC_RED;
                  end else begin
                     count_one_in = count_one_ff - 8'd1;
                     count_two_in = count_two_ff - 8'd1;
                  end
               end
               PH_ONE_GREEN: begin
                  pcount_in    = pcount_ff - 8'd1;
                  lamp_in[2:0] = LAMP_GREEN;
                  lamp_in[5:3] = LAMP_RED;
                  wcol_in      = WC_RED;
                  if (pcount_in == 8'd0) begin
                     pcount_in    = 8'(yellow_ff);
                     count_one_in = 8'(yellow_ff);
                     count_two_in = count_two_ff - 8'd1;
                     phase_in     = PH_ONE_YELLOW;
                     lamp_in[2:0] = LAMP_YELLOW;
                  end else begin
                     count_one_in = count_one_ff - 8'd1;
                     count_two_in = count_two_ff - 8'd1;
                  end
               end
               PH_ONE_YELLOW: begin
                  pcount_in    = pcount_ff - 8'd1;
                  lamp_in[2:0] = LAMP_YELLOW;
                  lamp_in[5:3] = LAMP_RED;
                  wcol_in      = WC_RED;
                  if (pcount_in == 8'd0) begin
                     pcount_in    = 8'(green_ff);
                     count_one_in = 8'(red_ff);
                     count_two_in = 8'(green_ff);
                     phase_in     = PH_TWO_GREEN;
                     lamp_in[5:3] = LAMP_GREEN;
                     lamp_in[2:0] = LAMP_RED;
                     wcol_in      = WC_GREEN;
                  end else begin
                     count_one_in = count_one_ff - 8'd1;
                     count_two_in = count_two_ff - 8'd1;
                  end
               end
               default: begin
                  phase_in = PH_INIT;
               end
            endcase
            if (walk_active_ff) begin
               walk_rem_in = walk_rem_ff - WALK_W'(1);
            end
         end

         if (req_data.mode_long_press) begin
            manual_in = 1'b1;
         end

         // Walk head still follows the sequencer in the step that enters manual.
         if (req_data.walk_request) begin
            walk_active_in = 1'b1;
            walk_rem_in    = walk_reload(red_ff, yellow_ff, green_ff);
         end
         if (walk_rem_in == '0) begin
            walk_active_in = 1'b0;
            lamp_in[8:6]   = LAMP_OFF;
            buzzer_in      = 1'b0;
            walk_rem_in    = walk_reload(red_ff, yellow_ff, green_ff);
         end
         if (walk_active_in) begin
            unique case (wcol_in)
               WC_GREEN: begin
                  lamp_in[8:6] = LAMP_GREEN;
                  if ((pcount_in <= BEEP_WINDOW) && req_data.beep_tick) begin
                     beep_in   = ~beep_ff;
                     buzzer_in = ~beep_ff;
                  end
               end
               WC_RED: begin
                  lamp_in[8:6] = LAMP_RED;
                  buzzer_in    = 1'b0;
               end
               WC_YELLOW: begin
                  lamp_in[8:6] = LAMP_YELLOW;
                  buzzer_in    = 1'b0;
               end
               default: begin
                  // No colour yet: the walk head keeps what it shows.
               end
            endcase
         end
      end else begin
         if (ecol_ff == EC_INIT) begin
            ecol_in = EC_RED;
            ebuf_in = red_ff;
         end
         c = ecol_in;

         unique case (c)
            EC_YELLOW: blink_bit = LAMP_YELLOW;
            EC_GREEN:  blink_bit = LAMP_GREEN;
            default:   blink_bit = LAMP_RED;
         endcase
         if (req_data.blink_tick) begin
            lamp_in[2:0] = (lamp_ff[2:0] ^ blink_bit) & blink_bit;
            lamp_in[5:3] = (lamp_ff[5:3] ^ blink_bit) & blink_bit;
         end

         if (req_data.mode_press) begin
            unique case (c)
               EC_RED:    c_next = EC_YELLOW;
               EC_YELLOW: c_next = EC_GREEN;
               default:   c_next = EC_RED;
            endcase
            ecol_in = c_next;
            unique case (c_next)
               EC_YELLOW: ebuf_in = yellow_ff;
               EC_GREEN:  ebuf_in = green_ff;
               default:   ebuf_in = red_ff;
            endcase
         end

         if (req_data.time_press) begin
            ebuf_in = (ebuf_in >= DUR_MAX) ? '0 : ebuf_in + DUR_ONE;
         end

         // Enter stores into the colour selected at the start of the request.
         if (req_data.enter_press) begin
            stored = (ebuf_in == '0) ? DUR_ONE : ebuf_in;
            unique case (c)
               EC_YELLOW: y = stored;
               EC_GREEN:  g = stored;
               default:   r = stored;
            endcase
            red_in    = r;
            yellow_in = y;
            green_in  = g;
            unique case (c)
               EC_YELLOW: begin
                  if (r < g) red_in = clamp_diff(g, y);
                  else       green_in = clamp_diff(r, y);
               end
               EC_GREEN: begin
                  if (r < g) red_in = clamp_diff(g, y);
                  else       yellow_in = clamp_diff(r, g);
               end
               default: begin
                  if (r < g) yellow_in = clamp_diff(g, r);
                  else       green_in = clamp_diff(r, y);
               end
            endcase
            walk_rem_in = walk_reload(red_in, yellow_in, green_in);
         end

         if (req_data.mode_long_press) begin
            manual_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         manual_ff      <= 1'b0;
         phase_ff       <= PH_INIT;
         pcount_ff      <= 8'd0;
         count_one_ff   <= 8'd0;
         count_two_ff   <= 8'd0;
         red_ff         <= DUR_W'(RED_RESET);
         yellow_ff      <= DUR_W'(YELLOW_RESET);
         green_ff       <= DUR_W'(GREEN_RESET);
         ecol_ff        <= EC_INIT;
         ebuf_ff        <= '0;
         walk_active_ff <= 1'b0;
         walk_rem_ff    <= WALK_W'(WALK_RESET);
         wcol_ff        <= WC_NONE;
         beep_ff        <= 1'b0;
         lamp_ff        <= '0;
         buzzer_ff      <= 1'b0;
      end else if (step_go) begin
         manual_ff      <= manual_in;
         phase_ff       <= phase_in;
         pcount_ff      <= pcount_in;
         count_one_ff   <= count_one_in;
         count_two_ff   <= count_two_in;
         red_ff         <= red_in;
         yellow_ff      <= yellow_in;
         green_ff       <= green_in;
         ecol_ff        <= ecol_in;
         ebuf_ff        <= ebuf_in;
         walk_active_ff <= walk_active_in;
         walk_rem_ff    <= walk_rem_in;
         wcol_ff        <= wcol_in;
         beep_ff        <= beep_in;
         lamp_ff        <= lamp_in;
         buzzer_ff      <= buzzer_in;
      end
   end

   // The result reflects the state as it stands after this request.
   always_comb begin
      rsp_data.road_one_lamps = lamp_in[2:0];
      rsp_data.road_two_lamps = lamp_in[5:3];
      rsp_data.walk_lamps     = lamp_in[8:6];
      rsp_data.buzzer_on      = buzzer_in;
      rsp_data.left_display   = count_one_in;
      rsp_data.right_display  = count_two_in;
      rsp_data.edit_value     = 7'(ebuf_in);
      rsp_data.in_manual      = manual_in;
      unique case (ecol_in)
         EC_YELLOW: rsp_data.edited_colour = SHOW_YELLOW;
         EC_GREEN:  rsp_data.edited_colour = SHOW_GREEN;
         default:   rsp_data.edited_colour = SHOW_RED;
      endcase
   end

endmodule

`default_nettype wire

@@ src/two_road_traffic_light_controller_core.sv @@
// ----------------------------------------------------------------------------
// two_road_traffic_light_controller_core
// Two-road traffic light controller with a pedestrian head, fed by tick and
// button requests over a valid/ready channel.
//
//   channel   direction  carries
//   req_bus   in         tick and button flags, one request per event
//   rsp_bus   out        lamps, buzzer, countdowns, edit buffer and mode
//
// Each request is held in an input register, updates the controller state
// and leaves its result in an output register, so one request per cycle is
// sustained while results are taken. A stalled result holds the update; the
// input register then fills and req_bus.ready drops. Reset is synchronous
// and restores the default durations and the automatic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module two_road_traffic_light_controller_core #(
   parameter int MAX_DURATION = 99
) (
   input  wire logic clock,
   input  wire logic reset,
   tlc_req_if.sink   req_bus,
   tlc_rsp_if.source rsp_bus
);
   import tlc_pkg::*;

   logic            in_valid_ff;
   req_payload_type in_data_ff, in_data_in;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type step_result;
   logic            step_go;

   assign step_go       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || step_go;

   assign in_data_in.second_tick     = req_bus.second_tick;
   assign in_data_in.blink_tick      = req_bus.blink_tick;
   assign in_data_in.beep_tick       = req_bus.beep_tick;
   assign in_data_in.mode_press      = req_bus.mode_press;
   assign in_data_in.mode_long_press = req_bus.mode_long_press;
   assign in_data_in.time_press      = req_bus.time_press;
   assign in_data_in.enter_press     = req_bus.enter_press;
   assign in_data_in.walk_request    = req_bus.walk_request;

   tlc_engine #(
      .MAX_DURATION(MAX_DURATION)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_go (step_go),
      .req_data(in_data_ff),
      .rsp_data(step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            in_valid_ff <= 1'b1;
         end else if (step_go) begin
            in_valid_ff <= 1'b0;
         end
         if (step_go) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_data_ff <= in_data_in;
      end
      if (step_go) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.road_one_lamps = out_data_ff.road_one_lamps;
   assign rsp_bus.road_two_lamps = out_data_ff.road_two_lamps;
   assign rsp_bus.walk_lamps     = out_data_ff.walk_lamps;
   assign rsp_bus.buzzer_on      = out_data_ff.buzzer_on;
   assign rsp_bus.left_display   = out_data_ff.left_display;
   assign rsp_bus.right_display  = out_data_ff.right_display;
   assign rsp_bus.edit_value     = out_data_ff.edit_value;
   assign rsp_bus.in_manual      = out_data_ff.in_manual;
   assign rsp_bus.edited_colour  = out_data_ff.edited_colour;

endmodule

`default_nettype wire
